// ===== hdl/mkdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkdc_pkg: shared definitions for the key debounce and chord unit
// Field widths, event codes, register indexes and the key event bundle.
// ----------------------------------------------------------------------------
package mkdc_pkg;

	localparam int TICK_W     = 32;
	localparam int PIN_W      = 5;
	localparam int DEB_W      = 16;
	localparam int KIND_W     = 2;
	localparam int KIDX_W     = 3;
	localparam int COMBO_W    = 6;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 16;
	localparam int M_TUSER_W  = KIND_W;

	localparam int CHORD_LO_KEY = 3;
	localparam int CHORD_HI_KEY = 4;
	localparam logic [COMBO_W-1:0] CHORD_BITS = 6'h30;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 4'd1;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;

	typedef enum logic [KIND_W-1:0] {
		EV_NONE,
		EV_PRESS,
		EV_RELEASE,
		EV_COMBO
	} event_kind_t;

	typedef struct packed {
		logic              hit;
		logic              press;
		logic [KIDX_W-1:0] idx;
	} key_evt_t;

endpackage

// ===== hdl/mkdc_chord.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkdc_chord: chord timer for keys 3 and 4
// Tracks when the chord was first held and fires one combo per hold.
// ----------------------------------------------------------------------------
module mkdc_chord
	import mkdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [TICK_W-1:0] now,
	input  logic              chord_on,
	input  logic [DEB_W-1:0]  debounce,
	output logic              combo
);

	logic              seen_q;
	logic              handled_q;
	logic [TICK_W-1:0] start_q;
	logic [TICK_W-1:0] start_d;
	logic              handled_d;

	always_comb begin
		start_d   = seen_q ? start_q : now;
		handled_d = seen_q & handled_q;
		combo     = chord_on & ~handled_d &
		            ((now - start_d) >= TICK_W'(debounce));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			handled_q <= 1'b0;
			start_q   <= '0;
		end else if (en) begin
			if (chord_on) begin
				seen_q    <= 1'b1;
				start_q   <= start_d;
				handled_q <= handled_d | combo;
			end else begin
				seen_q    <= 1'b0;
				handled_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/mkdc_key_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkdc_key_bank: per-key debounce state and priority scan
// All keys are timed in parallel; the lowest key with a new stable level wins.
// ----------------------------------------------------------------------------
module mkdc_key_bank
	import mkdc_pkg::*;
#(
	parameter int NUM_KEYS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [TICK_W-1:0]   now,
	input  logic [NUM_KEYS-1:0] pressed,
	input  logic [DEB_W-1:0]    debounce,
	output key_evt_t            evt
);

	localparam int KI_W = $clog2(NUM_KEYS);

	logic [NUM_KEYS-1:0] last_raw_q;
	logic [NUM_KEYS-1:0] stable_q;
	logic [NUM_KEYS-1:0] handled_q;
	logic [TICK_W-1:0]   change_tick_q [NUM_KEYS];

	logic [TICK_W-1:0]   tick_d [NUM_KEYS];
	logic [NUM_KEYS-1:0] handled_d;
	logic [NUM_KEYS-1:0] fire;
	logic [NUM_KEYS-1:0] ev;
	logic [NUM_KEYS-1:0] upd;
	logic [NUM_KEYS-1:0] first;
	logic [KI_W-1:0]     idx_full;

	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (pressed[k] != last_raw_q[k]) begin
				tick_d[k]    = now;
				handled_d[k] = 1'b0;
			end else begin
				tick_d[k]    = change_tick_q[k];
				handled_d[k] = handled_q[k];
			end
			fire[k]      = ~handled_d[k] & ((now - tick_d[k]) >= TICK_W'(debounce));
			ev[k]        = fire[k] & (pressed[k] != stable_q[k]);
			handled_d[k] = handled_d[k] | fire[k];
		end
		// Keys up to and including the winner are updated; all keys when none fires.
		upd      = ev ^ (ev - NUM_KEYS'(1));
		first    = ev & upd;
		idx_full = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (first[k]) begin
				idx_full = idx_full | KI_W'(k);
			end
		end
		evt.hit   = |ev;
		evt.press = |(first & pressed);
		evt.idx   = idx_full[KIDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= '0;
			stable_q      <= '0;
			handled_q     <= '0;
			change_tick_q <= '{default: '0};
		end else if (en) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (upd[k]) begin
					last_raw_q[k]    <= pressed[k];
					change_tick_q[k] <= tick_d[k];
					handled_q[k]     <= handled_d[k];
					if (first[k]) begin
						stable_q[k] <= pressed[k];
					end
				end
			end
		end
	end

endmodule

// ===== hdl/multi_key_debounce_with_combo_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_key_debounce_with_combo_unit: key debounce with chord detection
// Turns scan words of tick and pin levels into press, release and combo words.
// ----------------------------------------------------------------------------
// The unit takes scan words and returns exactly one result word for each,
// carried first in the input register and then in the result register.
// All keys and the chord timer are compared against the debounce time in
// parallel in the combinational logic between those two registers, so
// the rate is one word per cycle for as long as the result side
// takes words. Configuration writes complete at once and are meant to be
// made while no scan word is in flight.
// ----------------------------------------------------------------------------
module multi_key_debounce_with_combo_unit
	import mkdc_pkg::*;
#(
	parameter int NUM_KEYS = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // now_tick[31:0], pin_levels[36:32]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // key_index[2:0], combo_bits[8:3]
	output logic [M_TUSER_W-1:0]  m_tuser,   // event_kind[1:0]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [DEB_W-1:0]    debounce_q;
	logic [PIN_W-1:0]    polarity_q;

	logic                valid_s1;
	logic [TICK_W-1:0]   now_s1;
	logic [PIN_W-1:0]    pins_s1;

	logic                out_valid_q;
	event_kind_t         kind_q;
	logic [KIDX_W-1:0]   idx_q;
	logic [COMBO_W-1:0]  combo_bits_q;

	logic                advance;
	logic [NUM_KEYS-1:0] pressed;
	logic                chord_on;
	logic                combo;
	key_evt_t            key_evt;
	event_kind_t         kind_d;

	assign advance   = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready  = ~valid_s1 | advance;
	assign cfg_ready = 1'b1;

	assign pressed  = ~NUM_KEYS'(pins_s1 ^ polarity_q);
	assign chord_on = pressed[CHORD_LO_KEY] & pressed[CHORD_HI_KEY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			polarity_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE: begin
					debounce_q <= cfg_data;
				end
				REG_POLARITY: begin
					polarity_q <= cfg_data[PIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			now_s1   <= '0;
			pins_s1  <= '0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
			now_s1   <= s_tdata[TICK_W-1:0];
			pins_s1  <= s_tdata[TICK_W+PIN_W-1:TICK_W];
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	mkdc_chord u_chord (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.now      (now_s1),
		.chord_on (chord_on),
		.debounce (debounce_q),
		.combo    (combo)
	);

	mkdc_key_bank #(
		.NUM_KEYS (NUM_KEYS)
	) u_key_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance & ~combo),
		.now      (now_s1),
		.pressed  (pressed),
		.debounce (debounce_q),
		.evt      (key_evt)
	);

	always_comb begin
		if (combo) begin
			kind_d = EV_COMBO;
		end else if (key_evt.hit) begin
			kind_d = key_evt.press ? EV_PRESS : EV_RELEASE;
		end else begin
			kind_d = EV_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			kind_q       <= EV_NONE;
			idx_q        <= '0;
			combo_bits_q <= '0;
		end else if (advance) begin
			out_valid_q  <= 1'b1;
			kind_q       <= kind_d;
			idx_q        <= (combo || !key_evt.hit) ? '0 : key_evt.idx;
			combo_bits_q <= combo ? CHORD_BITS : '0;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'({combo_bits_q, idx_q});
	assign m_tuser  = kind_q;

`ifndef NO_ASSERTIONS
	a_combo_word: assert property (@(posedge clk) disable iff (!arst_n)
		advance && combo |=> m_tvalid && m_tuser == EV_COMBO &&
		m_tdata[KIDX_W-1:0] == '0 && m_tdata[KIDX_W+COMBO_W-1:KIDX_W] == CHORD_BITS)
		else $error("combo scan did not give a combo result word");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(now_s1) && $stable(pins_s1))
		else $error("input register lost a scan word");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed scan word gave no result word");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the key debounce and chord unit
// A short table of scan words covers the reset state, zero and maximum
// debounce times, tick wrap, chord hold and release and an ignored register
// index. Six randomized phases follow, each under its own register setting.
// A local model of the key and chord timers predicts each result word not
// fixed by the table, and both stream sides stall at random, including one
// long hold on the result side while the scan side keeps offering words.
// ----------------------------------------------------------------------------
module testbench
	import mkdc_pkg::*;
();

	localparam int QUIET_LIMIT = 5000;
	localparam int NUM_ROWS    = 26;
	localparam int PHASES      = 6;
	localparam int PHASE_WORDS = 215;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic [1:0] {
		ROW_SCAN,
		ROW_CFG
	} row_op_t;

	typedef struct packed {
		event_kind_t        kind;
		logic [KIDX_W-1:0]  key;
		logic [COMBO_W-1:0] combo;
	} scan_result_t;

	typedef struct packed {
		row_op_t              op;
		logic [TICK_W-1:0]    arg;
		logic [PIN_W-1:0]     pins;
		logic [CFG_IDX_W-1:0] ridx;
		logic                 typed;
		scan_result_t         want;
	} plan_row_t;

	localparam scan_result_t NO_EVENT    = '{EV_NONE, 3'd0, 6'd0};
	localparam scan_result_t COMBO_EVENT = '{EV_COMBO, 3'd0, CHORD_BITS};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // now_tick[31:0], pin_levels[36:32]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;   // key_index[2:0], combo_bits[8:3]
	logic [M_TUSER_W-1:0]  m_tuser;   // event_kind[1:0]
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	multi_key_debounce_with_combo_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	logic [DEB_W-1:0]  deb_ticks;
	logic [PIN_W-1:0]  high_mask;
	logic [PIN_W-1:0]  raw_seen;
	logic [PIN_W-1:0]  level_q;
	logic [PIN_W-1:0]  settled;
	logic [TICK_W-1:0] change_at [PIN_W];
	logic              chord_on;
	logic              chord_done;
	logic [TICK_W-1:0] chord_since;

	scan_result_t pending_events [$];
	scan_result_t head_event;
	plan_row_t    plan [NUM_ROWS];

	int  mismatches;
	int  words_sent;
	int  settings_used;
	int  presses;
	int  releases;
	int  combos;
	int  quiet_cycles;
	int  hold_left;
	bit  steady;
	bit  hold_request;
	bit  hold_taken;

	function automatic logic held_long(input logic [TICK_W-1:0] now,
	                                   input logic [TICK_W-1:0] since);
		logic [TICK_W-1:0] gap;
		gap = now - since;
		return gap >= {{(TICK_W-DEB_W){1'b0}}, deb_ticks};
	endfunction

	function automatic scan_result_t scan_keys(input logic [TICK_W-1:0] now,
	                                           input logic [PIN_W-1:0] pins);
		logic [PIN_W-1:0] down;
		scan_result_t     res;
		int               k;
		res = NO_EVENT;
		down = ~(pins ^ high_mask);
		if (down[CHORD_LO_KEY] && down[CHORD_HI_KEY]) begin
			if (!chord_on) begin
				chord_on = 1'b1;
				chord_since = now;
				chord_done = 1'b0;
			end
			if (!chord_done && held_long(now, chord_since)) begin
				chord_done = 1'b1;
				return COMBO_EVENT;
			end
		end else begin
			chord_on = 1'b0;
			chord_done = 1'b0;
		end
		for (k = 0; k < PIN_W; k++) begin
			if (down[k] != raw_seen[k]) begin
				change_at[k] = now;
				raw_seen[k] = down[k];
				settled[k] = 1'b0;
			end
			if (!settled[k] && held_long(now, change_at[k])) begin
				settled[k] = 1'b1;
				if (down[k] != level_q[k]) begin
					level_q[k] = down[k];
					res.kind = down[k] ? EV_PRESS : EV_RELEASE;
					res.key = k[KIDX_W-1:0];
					return res;
				end
			end
		end
		return res;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic send_scan(input logic [TICK_W-1:0] tick, input logic [PIN_W-1:0] pins,
	                         input logic typed, input scan_result_t want);
		scan_result_t predicted;
		if (!steady && $urandom_range(99) < 25) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W-TICK_W-PIN_W){1'b0}}, pins, tick};
		do @(posedge clk); while (!s_tready);
		predicted = scan_keys(tick, pins);
		pending_events.push_back(typed ? want : predicted);
		words_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_DEBOUNCE) begin
			deb_ticks = data;
		end else if (idx == REG_POLARITY) begin
			high_mask = data[PIN_W-1:0];
		end
		settings_used++;
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				flag_mismatch($sformatf("unexpected word kind=%0d tdata=%04h", m_tuser, m_tdata));
			end else begin
				head_event = pending_events.pop_front();
				if (m_tuser !== head_event.kind
				    || m_tdata[KIDX_W-1:0] !== head_event.key
				    || m_tdata[KIDX_W +: COMBO_W] !== head_event.combo
				    || m_tdata[M_TDATA_W-1:KIDX_W+COMBO_W] !== '0) begin
					flag_mismatch($sformatf("kind %0d/%0d key %0d/%0d combo %02h/%02h tdata %04h",
						m_tuser, head_event.kind, m_tdata[KIDX_W-1:0], head_event.key,
						m_tdata[KIDX_W +: COMBO_W], head_event.combo, m_tdata));
				end
				case (head_event.kind)
					EV_PRESS:   presses++;
					EV_RELEASE: releases++;
					EV_COMBO:   combos++;
					default:    ;
				endcase
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_request && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 25);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout after %0d cycles with no word accepted", quiet_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int                    i;
		int                    p;
		int                    n;
		int                    step_max;
		int                    roll;
		logic [TICK_W-1:0]     tick;
		logic [PIN_W-1:0]      pins;
		logic [DEB_W-1:0]      deb_pick;
		logic [CFG_DATA_W-1:0] pol_pick;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		deb_ticks = DEBOUNCE_RESET;
		high_mask = '0;
		raw_seen = '0;
		level_q = '0;
		settled = '0;
		for (i = 0; i < PIN_W; i++) change_at[i] = '0;
		chord_on = 1'b0;
		chord_done = 1'b0;
		chord_since = '0;
		mismatches = 0;
		words_sent = 0;
		settings_used = 0;
		presses = 0;
		releases = 0;
		combos = 0;
		quiet_cycles = 0;
		hold_left = 0;
		steady = 1'b0;
		hold_request = 1'b0;
		hold_taken = 1'b0;

		plan = '{
			'{ROW_SCAN, 32'd0,          5'h1F, 4'd0, 1'b1, NO_EVENT},
			'{ROW_SCAN, 32'd20,         5'h1F, 4'd0, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'd30,         5'h00, 4'd0, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'd50,         5'h00, 4'd0, 1'b1, COMBO_EVENT},
			'{ROW_SCAN, 32'd51,         5'h00, 4'd0, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'd52,         5'h00, 4'd0, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'd60,         5'h08, 4'd0, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'd90,         5'h1F, 4'd0, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'd95,         5'h1F, 4'd0, 1'b0, NO_EVENT},
			'{ROW_CFG,  32'h0000,       5'h00, REG_DEBOUNCE, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'd100,        5'h1E, 4'd0, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'd100,        5'h1F, 4'd0, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'd101,        5'h07, 4'd0, 1'b1, COMBO_EVENT},
			'{ROW_SCAN, 32'd102,        5'h07, 4'd0, 1'b0, NO_EVENT},
			'{ROW_CFG,  32'hFFFF,       5'h00, 4'd9, 1'b0, NO_EVENT},
			'{ROW_CFG,  32'hFFFF,       5'h00, REG_POLARITY, 1'b0, NO_EVENT},
			'{ROW_CFG,  32'hFFFF,       5'h00, REG_DEBOUNCE, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'hFFFF_FFF0,  5'h00, 4'd0, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'h0000_FFEF,  5'h00, 4'd0, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'h0001_0000,  5'h18, 4'd0, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'h0002_0000,  5'h18, 4'd0, 1'b1, COMBO_EVENT},
			'{ROW_CFG,  32'h000A,       5'h00, REG_POLARITY, 1'b0, NO_EVENT},
			'{ROW_CFG,  32'h0001,       5'h00, REG_DEBOUNCE, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'd5,          5'h15, 4'd0, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'd6,          5'h15, 4'd0, 1'b0, NO_EVENT},
			'{ROW_SCAN, 32'd7,          5'h0A, 4'd0, 1'b0, NO_EVENT}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < NUM_ROWS; i++) begin
			if (plan[i].op == ROW_CFG) begin
				if (i == 0 || plan[i-1].op != ROW_CFG) wait_drained();
				write_reg(plan[i].ridx, plan[i].arg[CFG_DATA_W-1:0]);
				if (i == NUM_ROWS - 1 || plan[i+1].op != ROW_CFG) cfg_valid <= 1'b0;
			end else begin
				send_scan(plan[i].arg, plan[i].pins, plan[i].typed, plan[i].want);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					deb_pick = '0;
					pol_pick = '0;
				end
				1: begin
					deb_pick = DEB_W'(1);
					pol_pick = '1;
				end
				2: begin
					deb_pick = DEB_W'($urandom_range(30, 2));
					pol_pick = CFG_DATA_W'($urandom);
				end
				3: begin
					deb_pick = '1;
					pol_pick = CFG_DATA_W'($urandom);
				end
				4: begin
					deb_pick = DEB_W'($urandom);
					pol_pick = CFG_DATA_W'($urandom);
				end
				default: begin
					deb_pick = DEB_W'($urandom_range(12, 3));
					pol_pick = CFG_DATA_W'($urandom);
				end
			endcase
			wait_drained();
			write_reg(REG_DEBOUNCE, deb_pick);
			write_reg(REG_POLARITY, pol_pick);
			write_reg(CFG_IDX_W'($urandom_range(15, REG_POLARITY + 1)), CFG_DATA_W'($urandom));
			cfg_valid <= 1'b0;

			steady = (p == 2);
			tick = (p == 3) ? 32'hFFFF_0000 + $urandom_range(4095, 0) : $urandom;
			pins = PIN_W'($urandom);
			step_max = int'(deb_pick) / 3 + 2;
			for (n = 0; n < PHASE_WORDS; n++) begin
				if (p == 1 && n == 100) hold_request = 1'b1;
				if (p == 4 && n == 110) wait_drained();
				roll = $urandom_range(99);
				if (roll < 3) begin
					tick = $urandom;
				end else begin
					tick = tick + $urandom_range(step_max, 0);
				end
				roll = $urandom_range(99);
				if (roll >= 60 && roll < 85) begin
					pins = pins ^ PIN_W'(1 << $urandom_range(PIN_W - 1, 0));
				end else if (roll >= 85 && roll < 93) begin
					pins[CHORD_LO_KEY] = high_mask[CHORD_LO_KEY];
					pins[CHORD_HI_KEY] = high_mask[CHORD_HI_KEY];
				end else if (roll >= 93) begin
					pins = PIN_W'($urandom);
				end
				send_scan(tick, pins, 1'b0, NO_EVENT);
			end
		end

		steady = 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		if (pending_events.size() != 0) begin
			flag_mismatch($sformatf("%0d result words never arrived", pending_events.size()));
		end
		$display("Ran %0d scan words under %0d register writes across %0d random phases.",
			words_sent, settings_used, PHASES);
		$display("Checked %0d press, %0d release and %0d combo words; %0d mismatches.",
			presses, releases, combos, mismatches);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
